FILE: rtl/world_to_screen_projection_assert.svh
// Assertion macros shared by the projection RTL.
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH

// Implication checked on the same clock edge.
`define WSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the following clock edge.
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wsp_pkg.sv
// Shared types and constants of the world-to-screen projection block.
`timescale 1ns / 1ps
package wsp_pkg;
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PROJECT = 1'b1
    } t_op;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    localparam int COEF_W     = 32;
    localparam int SIZE_W     = 15;
    localparam int HALF_W     = 14;
    localparam int QUOT_W     = 41;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 64;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 15'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 15'd1080;
endpackage

FILE: rtl/world_to_screen_projection.sv
// Top level of the world-to-screen perspective projection pipeline.
`timescale 1ns / 1ps
// Usage:
// - Input stream (i_s_*): tuser is the operation. A load transaction writes one of
//   sixteen column-major matrix coefficients and gives no result; a project
//   transaction gives exactly one result transaction on the output stream.
// - Output stream (o_m_*): tuser is the visible flag, tdata holds screen x and y
//   in signed fixed point; both are zero for points behind the near threshold.
// - Config channel (i_cfg_*): index 0 is screen width, index 1 screen height.
//   It is always ready; write it only while the pipeline is empty.
// - Pipeline: a project transaction passes 46 registers from the input to the
//   output, the first loaded at the edge that accepts it: one stage each for the
//   products, the clip sums and the scaling multiply, 42 for the divider (overflow
//   check, then one quotient bit a stage), one output register.
// - Throughput: one transaction per cycle, loads and projects alike, unless stalled.
// - Reset clears all valid bits and the matrix, and loads 1920 x 1080.
// - A stalled receiver freezes every stage together; o_s_tready drops only while
//   a result waits in the output register and the receiver holds tready low.
module world_to_screen_projection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [3:0] coef_index, [35:4] coef_value, [67:36] pos_x, [99:68] pos_y,
    // [131:100] pos_z, [135:132] zero
    input  logic [wsp_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [0] operation
    input  logic                           i_s_tuser,
    // Output stream.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] screen_x, [63:32] screen_y
    output logic [wsp_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // [0] visible
    output logic                           o_m_tuser,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [wsp_pkg::SIZE_W-1:0]     i_cfg_data
);
`include "world_to_screen_projection_assert.svh"

    localparam int CW  = 64 - FRAC_BITS + 3;          // clip value width
    localparam int HW  = wsp_pkg::HALF_W;
    localparam int NW  = CW + HW + FRAC_BITS;         // dividend width
    localparam int QW  = wsp_pkg::QUOT_W;
    localparam int EW  = QW + 2;                      // signed screen sum width
    localparam int TXW = 2 + HW;
    localparam int TYW = 1 + HW;
    localparam logic signed [CW-1:0] THR = CW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [EW-1:0] SAT_HI = EW'(64'sh7FFF_FFFF);
    localparam logic signed [EW-1:0] SAT_LO = -EW'(64'sh8000_0000);

    // Unpack input fields.
    logic               [3:0]  w_idx;
    logic signed        [31:0] w_coef, w_px, w_py, w_pz;
    wsp_pkg::t_op              w_op;
    assign w_idx  = i_s_tdata[3:0];
    assign w_coef = i_s_tdata[35:4];
    assign w_px   = i_s_tdata[67:36];
    assign w_py   = i_s_tdata[99:68];
    assign w_pz   = i_s_tdata[131:100];
    assign w_op   = wsp_pkg::t_op'(i_s_tuser);

    logic w_en, w_acc;
    logic r_out_vld;
    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;
    assign w_acc      = i_s_tvalid && w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    logic [wsp_pkg::SIZE_W-1:0] r_width, r_height;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= wsp_pkg::WIDTH_RST;
            r_height <= wsp_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (wsp_pkg::t_cfg_idx'(i_cfg_index))
                wsp_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                wsp_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Matrix store; a load lands before any later point reads it.
    logic signed [31:0] r_mat [16];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_mat[i] <= '0;
        end else if (w_acc && w_op == wsp_pkg::OP_LOAD) begin
            r_mat[w_idx] <= w_coef;
        end
    end

    // Stage 1: nine products for clip rows x, y and w, plus translations.
    logic               r_s1_vld;
    logic signed [63:0] r_s1_p [9];
    logic signed [31:0] r_s1_t [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= w_acc && w_op == wsp_pkg::OP_PROJECT;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_s1_p[3*j]   <= w_px * r_mat[(j == 2) ? 3 : j];
                r_s1_p[3*j+1] <= w_py * r_mat[4 + ((j == 2) ? 3 : j)];
                r_s1_p[3*j+2] <= w_pz * r_mat[8 + ((j == 2) ? 3 : j)];
                r_s1_t[j]     <= r_mat[12 + ((j == 2) ? 3 : j)];
            end
        end
    end

    // Stage 2: floor-shift products and sum into clip coordinates.
    logic                 r_s2_vld;
    logic signed [CW-1:0] r_s2_c [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_s2_c[j] <= CW'(r_s1_p[3*j] >>> FRAC_BITS)
                           + CW'(r_s1_p[3*j+1] >>> FRAC_BITS)
                           + CW'(r_s1_p[3*j+2] >>> FRAC_BITS) + CW'(r_s1_t[j]);
            end
        end
    end

    // Stage 3: visibility, magnitudes and scaling by the half sizes.
    logic [CW-1:0] w_magx, w_magy;
    logic [HW-1:0] w_hx, w_hy;
    assign w_magx = r_s2_c[0][CW-1] ? CW'(-r_s2_c[0]) : CW'(r_s2_c[0]);
    assign w_magy = r_s2_c[1][CW-1] ? CW'(-r_s2_c[1]) : CW'(r_s2_c[1]);
    assign w_hx   = r_width[wsp_pkg::SIZE_W-1:1];
    assign w_hy   = r_height[wsp_pkg::SIZE_W-1:1];

    logic           r_s3_vld;
    logic [NW-1:0]  r_s3_nx, r_s3_ny;
    logic [CW-1:0]  r_s3_den;
    logic [TXW-1:0] r_s3_tx;
    logic [TYW-1:0] r_s3_ty;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_s2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_nx  <= (NW'(w_magx) * NW'(w_hx)) << FRAC_BITS;
            r_s3_ny  <= (NW'(w_magy) * NW'(w_hy)) << FRAC_BITS;
            r_s3_den <= r_s2_c[2];
            // y axis is mirrored: negative result for non-negative clip y.
            r_s3_tx  <= {r_s2_c[2] >= THR, r_s2_c[0][CW-1], w_hx};
            r_s3_ty  <= {!r_s2_c[1][CW-1], w_hy};
        end
    end

    // Divider pipelines, one per axis, stepping in lockstep.
    logic           w_vx, w_vy;
    logic [QW-1:0]  w_qx, w_qy;
    logic [TXW-1:0] w_tx;
    logic [TYW-1:0] w_ty;

    wsp_div #(.DW(CW), .NW(NW), .QW(QW), .TW(TXW)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_s3_vld),
        .i_num(r_s3_nx), .i_den(r_s3_den), .i_tag(r_s3_tx),
        .o_vld(w_vx), .o_quot(w_qx), .o_tag(w_tx)
    );

    wsp_div #(.DW(CW), .NW(NW), .QW(QW), .TW(TYW)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r_s3_vld),
        .i_num(r_s3_ny), .i_den(r_s3_den), .i_tag(r_s3_ty),
        .o_vld(w_vy), .o_quot(w_qy), .o_tag(w_ty)
    );

    // Apply sign, add the half-size offset and saturate to 32 bits.
    logic signed [EW-1:0] w_qsx, w_qsy, w_sx, w_sy;
    logic        [31:0]   w_ox, w_oy;
    logic                 w_vis;
    assign w_vis = w_tx[TXW-1];
    assign w_qsx = w_tx[HW] ? -EW'(w_qx) : EW'(w_qx);
    assign w_qsy = w_ty[HW] ? -EW'(w_qy) : EW'(w_qy);
    assign w_sx  = w_qsx + (EW'(w_tx[HW-1:0]) << FRAC_BITS);
    assign w_sy  = w_qsy + (EW'(w_ty[HW-1:0]) << FRAC_BITS);
    assign w_ox  = (w_sx > SAT_HI) ? 32'h7FFF_FFFF :
                   (w_sx < SAT_LO) ? 32'h8000_0000 : w_sx[31:0];
    assign w_oy  = (w_sy > SAT_HI) ? 32'h7FFF_FFFF :
                   (w_sy < SAT_LO) ? 32'h8000_0000 : w_sy[31:0];

    // Output register: hold while the receiver stalls.
    logic [wsp_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                           r_out_vis;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_vx;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_vis  <= w_vis;
            r_out_data <= w_vis ? {w_oy, w_ox} : '0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_vis;

    `WSP_ASSERT_SAME(a_div_lockstep, 1'b1, w_vx == w_vy, "axis dividers out of step")
    `WSP_ASSERT_SAME(a_hidden_zero, o_m_tvalid && !o_m_tuser, o_m_tdata == '0,
        "hidden point with nonzero coordinates")
    `WSP_ASSERT_SAME(a_stall_cause, !o_s_tready, o_m_tvalid && !i_m_tready,
        "input stalled without a waiting result")
    `WSP_ASSERT_NEXT(a_load_silent, w_acc && w_op == wsp_pkg::OP_LOAD, !r_s1_vld,
        "load transaction entered the result path")
endmodule

FILE: rtl/wsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
`timescale 1ns / 1ps
module wsp_div #(
    parameter int DW = 51,
    parameter int NW = 81,
    parameter int QW = 41,
    parameter int TW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [QW-1:0] o_quot,
    output logic [TW-1:0] o_tag
);
    localparam int HW = NW - QW;
    localparam logic [QW-1:0] CAP = QW'(1) << (QW - 1);

    logic          r_vld [QW+1];
    logic          r_ovf [QW+1];
    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_lo  [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic [TW-1:0] r_tag [QW+1];

    logic [HW-1:0] w_hi;
    assign w_hi = i_num[NW-1:QW];

    // Stage 0: quotient overflow check and first partial remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= DW'(w_hi) >= i_den;
            r_rem[0] <= DW'(w_hi);
            r_lo[0]  <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [DW:0] w_trial;
        logic        w_ge;
        logic [DW:0] w_diff;

        assign w_trial = {r_rem[k-1], r_lo[k-1][QW-k]};
        assign w_ge    = w_trial >= {1'b0, r_den[k-1]};
        assign w_diff  = w_trial - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k] <= r_ovf[k-1];
                r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_lo[k]  <= r_lo[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= r_q[k-1] | (QW'(w_ge) << (QW - k));
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // Clamp large quotients to the cap.
    assign o_vld  = r_vld[QW];
    assign o_quot = (r_ovf[QW] || r_q[QW] > CAP) ? CAP : r_q[QW];
    assign o_tag  = r_tag[QW];
endmodule

FILE: sim/world_to_screen_projection_tb.sv
// Self-checking testbench for the world-to-screen projection block.
`timescale 1ns / 1ps
module world_to_screen_projection_tb;

    localparam int FRAC       = 16;
    localparam int PIPE_DRAIN = 60;     // drain margin, longer than the block pipeline
    localparam int IDLE_LIMIT = 1000;   // cycles with no transaction at all
    localparam int RAND_ITEMS = 240;    // random items per size setting
    localparam longint W_THRESH = ((64'd1 << FRAC) + 5) / 10;
    localparam longint QUOT_MAX = 64'd1 << 40;

    typedef struct packed {
        logic        visible;
        logic [31:0] sx;
        logic [31:0] sy;
    } t_screen_pt;

    typedef struct {
        wsp_pkg::t_op op;
        logic [3:0]   idx;
        logic [31:0]  coef;
        logic [31:0]  px, py, pz;
        bit           typed;     // expected result written out by hand
        t_screen_pt   want;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [wsp_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                           i_s_tuser = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [wsp_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                           o_m_tuser;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic                           i_cfg_index = 1'b0;
    logic [wsp_pkg::SIZE_W-1:0]     i_cfg_data = '0;

    world_to_screen_projection uut (.*);

    // Predictor state: matrix and viewport size as the block should hold them.
    logic signed [31:0]         coef_mirror [16];
    logic [wsp_pkg::SIZE_W-1:0] width_mirror  = wsp_pkg::WIDTH_RST;
    logic [wsp_pkg::SIZE_W-1:0] height_mirror = wsp_pkg::HEIGHT_RST;

    t_screen_pt pending_pts[$];
    t_stim_row  directed_rows[$];
    int         mismatch_cnt = 0;
    int         n_loads = 0, n_projects = 0, n_visible = 0, n_hidden = 0;
    bit         send_pauses = 1'b0;
    bit         recv_stalls = 1'b0;
    int         stall_left = 0;
    int         idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Short gaps mostly, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One clip coordinate: row r of the matrix against (x, y, z, 1).
    function automatic longint clip_dot(int r, logic signed [31:0] x,
                                        logic signed [31:0] y, logic signed [31:0] z);
        longint acc;
        acc = (longint'(x) * longint'(coef_mirror[r])) >>> FRAC;
        acc += (longint'(y) * longint'(coef_mirror[4 + r])) >>> FRAC;
        acc += (longint'(z) * longint'(coef_mirror[8 + r])) >>> FRAC;
        return acc + longint'(coef_mirror[12 + r]);
    endfunction

    // Scale one clip coordinate to pixels: half * c / w + half, saturated.
    function automatic logic [31:0] viewport_axis(longint c, longint w,
                                                  logic [wsp_pkg::SIZE_W-1:0] size, bit flip);
        bit [127:0] num;
        bit [127:0] quo;
        longint     half, mag, q, s;
        half = longint'(size >> 1);
        mag  = (c < 0) ? -c : c;
        num  = {64'd0, mag};
        num  = (num * half) << FRAC;
        quo  = num / {64'd0, w};
        q    = (quo > QUOT_MAX) ? QUOT_MAX : longint'(quo[63:0]);
        if ((c < 0) != flip) q = -q;
        s = q + (half << FRAC);
        if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
        if (s < -64'sh8000_0000) s = -64'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic t_screen_pt project_point(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z);
        t_screen_pt pt;
        longint cx, cy, cw;
        cx = clip_dot(0, x, y, z);
        cy = clip_dot(1, x, y, z);
        cw = clip_dot(3, x, y, z);
        pt = '0;
        if (cw >= W_THRESH) begin
            pt.visible = 1'b1;
            pt.sx = viewport_axis(cx, cw, width_mirror, 1'b0);
            pt.sy = viewport_axis(cy, cw, height_mirror, 1'b1);
        end
        return pt;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h (t=%0t)", field, got, want, $realtime);
        mismatch_cnt++;
    endtask

    // Wide-ranging fixed-point word: full random, small, extreme or mid-sized.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    // Keep the w row mostly small with a positive offset so many points land in view.
    function automatic logic [31:0] rand_coef(logic [3:0] idx);
        if ($urandom_range(0, 9) == 0) return $urandom;
        if (idx == 4'd3 || idx == 4'd7 || idx == 4'd11)
            return $urandom_range(0, 32'h2000) - 32'h1000;
        if (idx == 4'd15)
            return $urandom_range(6000, 32'h0040_0000);
        return rand_word();
    endfunction

    // Hold one item on the input stream until it is taken, then predict it.
    task automatic send_item(t_stim_row row);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= row.op;
        i_s_tdata  <= {4'b0, row.pz, row.py, row.px, row.coef, row.idx};
        do @(posedge i_clk); while (!o_s_tready);
        if (row.op == wsp_pkg::OP_LOAD) begin
            coef_mirror[row.idx] = row.coef;
            n_loads++;
        end else begin
            pending_pts.push_back(row.typed ? row.want : project_point(row.px, row.py, row.pz));
            n_projects++;
        end
        gap = send_pauses ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and idle before returning so back-to-back writes never collide.
    task automatic write_size(wsp_pkg::t_cfg_idx which, logic [wsp_pkg::SIZE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (which == wsp_pkg::CFG_WIDTH) width_mirror = value;
        else height_mirror = value;
    endtask

    // Let every result come back, then let any trailing load leave the pipe.
    task automatic drain_pipe();
        i_s_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic add_row(wsp_pkg::t_op op, logic [3:0] idx, logic [31:0] coef,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           bit typed = 1'b0, t_screen_pt want = '0);
        t_stim_row row;
        row.op = op; row.idx = idx; row.coef = coef;
        row.px = x; row.py = y; row.pz = z;
        row.typed = typed; row.want = want;
        directed_rows.push_back(row);
    endtask

    // Receiver: random stalls, mostly short, disabled in some phases.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Compare each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_screen_pt want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pts.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[31:0], 32'h0);
            end else begin
                want = pending_pts.pop_front();
                if (o_m_tuser !== want.visible)
                    report_mismatch("visible", o_m_tuser, want.visible);
                if (o_m_tdata[31:0] !== want.sx)
                    report_mismatch("screen_x", o_m_tdata[31:0], want.sx);
                if (o_m_tdata[63:32] !== want.sy)
                    report_mismatch("screen_y", o_m_tdata[63:32], want.sy);
                if (want.visible) n_visible++;
                else n_hidden++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_pts.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [wsp_pkg::SIZE_W-1:0] w_set [6];
        logic [wsp_pkg::SIZE_W-1:0] h_set [6];
        t_stim_row row;
        logic [3:0] idx;
        for (int i = 0; i < 16; i++) coef_mirror[i] = '0;
        w_set = '{wsp_pkg::WIDTH_RST, 15'd0, 15'd1, 15'd32767, 15'd16384, 15'd640};
        h_set = '{wsp_pkg::HEIGHT_RST, 15'd0, 15'd32767, 15'd1, 15'd16384, 15'd480};
        w_set[5] = $urandom_range(1, 16384);
        h_set[5] = $urandom_range(1, 16384);

        // Directed part: zero matrix, origin, the near threshold, extremes.
        add_row(wsp_pkg::OP_PROJECT, 4'd9, 32'hDEAD_BEEF, 32'd1, 32'd2, 32'd3, 1'b1, '0);
        add_row(wsp_pkg::OP_LOAD, 4'd15, 32'h0001_0000, $urandom, $urandom, $urandom);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'd0, 32'd0, 32'd0, 1'b1,
                '{1'b1, 32'd960 << FRAC, 32'd540 << FRAC});
        add_row(wsp_pkg::OP_LOAD, 4'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_LOAD, 4'd5, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'h0000_8000, 32'hFFFF_8000, 32'd0);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        add_row(wsp_pkg::OP_PROJECT, 4'hF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF);
        add_row(wsp_pkg::OP_LOAD, 4'd15, 32'd6554, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'd0, 32'd0, 32'd0, 1'b1,
                '{1'b1, 32'd960 << FRAC, 32'd540 << FRAC});
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        add_row(wsp_pkg::OP_LOAD, 4'd15, 32'd6553, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd0,
                1'b1, '0);
        add_row(wsp_pkg::OP_LOAD, 4'd15, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_LOAD, 4'd11, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
        add_row(wsp_pkg::OP_LOAD, 4'd12, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_LOAD, 4'd13, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        add_row(wsp_pkg::OP_LOAD, 4'd11, 32'h0, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_LOAD, 4'd15, 32'd6554, 32'h0, 32'h0, 32'h0);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'd0, 32'd0, 32'd0);
        add_row(wsp_pkg::OP_PROJECT, 4'd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h1234_5678);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) send_item(directed_rows[i]);
        drain_pipe();

        // Random part: one phase per viewport setting, reset sizes first.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_size(wsp_pkg::CFG_WIDTH, w_set[ph]);
                write_size(wsp_pkg::CFG_HEIGHT, h_set[ph]);
            end
            send_pauses = (ph % 3) != 1;
            recv_stalls = (ph % 3) != 2;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                idx = $urandom_range(0, 15);
                row.idx  = idx;
                row.px   = rand_word();
                row.py   = rand_word();
                row.pz   = rand_word();
                row.typed = 1'b0;
                row.want  = '0;
                if ($urandom_range(0, 9) < 3) begin
                    row.op   = wsp_pkg::OP_LOAD;
                    row.coef = rand_coef(idx);
                end else begin
                    row.op   = wsp_pkg::OP_PROJECT;
                    row.coef = $urandom;
                end
                send_item(row);
            end
            drain_pipe();
        end

        $display("sent %0d loads and %0d projections over 6 viewport sizes", n_loads, n_projects);
        $display("checked %0d visible and %0d hidden points", n_visible, n_hidden);
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
